// File: sv/lzwc_pkg.sv
package lzwc_pkg;

  localparam int CODE_BITS   = 12;
  localparam int SYM_BITS    = 8;
  localparam int FREE_BITS   = CODE_BITS + 1;
  localparam int WIDTH_BITS  = 4;
  localparam int METRIC_BITS = 16;
  localparam int THR_BITS    = 11;
  localparam int ENTRY_BITS  = CODE_BITS + SYM_BITS;
  localparam int TABLE_SIZE  = 1 << CODE_BITS;

  localparam logic [CODE_BITS-1:0]  NUM_SYMS    = CODE_BITS'(1 << SYM_BITS);
  localparam logic [CODE_BITS-1:0]  CLEAR_CODE  = CODE_BITS'(1 << SYM_BITS);
  localparam logic [CODE_BITS-1:0]  STOP_CODE   = CODE_BITS'((1 << SYM_BITS) + 1);
  localparam logic [CODE_BITS-1:0]  FIRST_FREE  = CODE_BITS'((1 << SYM_BITS) + 2);
  localparam logic [FREE_BITS-1:0]  TABLE_FULL  = FREE_BITS'(TABLE_SIZE);
  localparam logic [WIDTH_BITS-1:0] START_WIDTH = WIDTH_BITS'(SYM_BITS + 1);
  localparam logic [WIDTH_BITS-1:0] MAX_WIDTH   = WIDTH_BITS'(CODE_BITS);
  localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(-10);

  localparam logic [METRIC_BITS-1:0] METRIC_MIN = {1'b1, {(METRIC_BITS-1){1'b0}}};
  localparam logic [METRIC_BITS-1:0] METRIC_MAX = {1'b0, {(METRIC_BITS-1){1'b1}}};

  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [SYM_BITS-1:0] symbol;
  } in_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]  code;
    logic [WIDTH_BITS-1:0] code_width;
    logic                  last;
  } out_t;

endpackage

// File: sv/lzwc_ram.sv
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lzw_compressor_unit.sv
// LZW compressor with variable code width (9 to 12 bits).
// Input channel: in_valid/in_stall carries one item, either a data symbol or
// a finish command. Output channel: out_valid/out_stall carries result items,
// each a code, its width and a last flag; an input item causes zero, one or
// two results. cfg_wr_en/cfg_wr_data write the clear threshold. The user
// must write it only while the block is idle; the block does not enforce it.
// A data item is matched against the dictionary by a linear scan through one
// memory read port: each stored entry is read (ST_READ) and then compared
// (ST_CMP). Up to 3838 entries may be scanned.
// One item is processed at a time: in_stall is high while an accepted item
// is scanned or its results are delivered.
// Reset (rst_n low at a clock edge) empties the dictionary, clears the
// pending prefix and sets the threshold to -10; no clearing pass is needed.
// While out_stall is high the current result holds and no new item is taken.
module lzw_compressor_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lzwc_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lzwc_pkg::out_t      out_data,
  input  logic                cfg_wr_en,
  input  logic [lzwc_pkg::THR_BITS-1:0] cfg_wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [lzwc_pkg::FREE_BITS-1:0]   free_r, free_nxt;
  logic [lzwc_pkg::CODE_BITS-1:0]   pend_r, pend_nxt;
  logic                             pvalid_r, pvalid_nxt;
  logic [lzwc_pkg::WIDTH_BITS-1:0]  width_r, width_nxt;
  logic [lzwc_pkg::METRIC_BITS-1:0] metric_r, metric_nxt;
  logic [lzwc_pkg::THR_BITS-1:0]    thr_r;
  logic [lzwc_pkg::SYM_BITS-1:0]    sym_r, sym_nxt;
  logic [lzwc_pkg::CODE_BITS-1:0]   scan_r, scan_nxt;
  lzwc_pkg::out_t                   res0_r, res0_nxt, res1_r, res1_nxt;
  logic                             two_r, two_nxt;

  logic                             ram_we;
  logic [lzwc_pkg::CODE_BITS-1:0]   ram_waddr;
  logic [lzwc_pkg::ENTRY_BITS-1:0]  ram_wdata, ram_rdata;

  logic                             in_acc, out_acc, do_nm;
  logic [lzwc_pkg::FREE_BITS-1:0]   free_inc;
  logic [lzwc_pkg::METRIC_BITS-1:0] metric_new;
  logic [lzwc_pkg::CODE_BITS:0]     scan_inc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_EMIT);
  assign out_acc   = out_valid && !out_stall;
  assign out_data  = res0_r;
  assign free_inc  = free_r + lzwc_pkg::FREE_BITS'(1);
  assign scan_inc  = {1'b0, scan_r} + (lzwc_pkg::CODE_BITS+1)'(1);

  lzwc_ram #(
    .WIDTH(lzwc_pkg::ENTRY_BITS),
    .DEPTH(lzwc_pkg::TABLE_SIZE)
  ) u_dict (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_r),
    .rdata(ram_rdata)
  );

  // Metric step once the table is full: literals lower it, others raise it.
  always_comb begin
    metric_new = metric_r;
    if (pend_r < lzwc_pkg::NUM_SYMS) begin
      if (metric_r != lzwc_pkg::METRIC_MIN) begin
        metric_new = metric_r - lzwc_pkg::METRIC_BITS'(1);
      end
    end else if (metric_r != lzwc_pkg::METRIC_MAX) begin
      metric_new = metric_r + lzwc_pkg::METRIC_BITS'(1);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    free_nxt   = free_r;
    pend_nxt   = pend_r;
    pvalid_nxt = pvalid_r;
    width_nxt  = width_r;
    metric_nxt = metric_r;
    sym_nxt    = sym_r;
    scan_nxt   = scan_r;
    res0_nxt   = res0_r;
    res1_nxt   = res1_r;
    two_nxt    = two_r;
    ram_we     = 1'b0;
    ram_waddr  = free_r[lzwc_pkg::CODE_BITS-1:0];
    ram_wdata  = {pend_r, sym_r};
    do_nm      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sym_nxt = in_data.symbol;
          if (in_data.operation == lzwc_pkg::OP_FINISH) begin
            res1_nxt = '{code: lzwc_pkg::STOP_CODE, code_width: width_r, last: 1'b1};
            if (pvalid_r) begin
              res0_nxt = '{code: pend_r, code_width: width_r, last: 1'b0};
              two_nxt  = 1'b1;
            end else begin
              res0_nxt = '{code: lzwc_pkg::STOP_CODE, code_width: width_r, last: 1'b1};
              two_nxt  = 1'b0;
            end
            free_nxt   = lzwc_pkg::FREE_BITS'(lzwc_pkg::FIRST_FREE);
            width_nxt  = lzwc_pkg::START_WIDTH;
            metric_nxt = '0;
            pend_nxt   = '0;
            pvalid_nxt = 1'b0;
            state_nxt  = ST_EMIT;
          end else if (!pvalid_r) begin
            pend_nxt   = lzwc_pkg::CODE_BITS'(in_data.symbol);
            pvalid_nxt = 1'b1;
          end else begin
            scan_nxt  = lzwc_pkg::FIRST_FREE;
            state_nxt = (free_r > lzwc_pkg::FREE_BITS'(lzwc_pkg::FIRST_FREE)) ?
                        ST_READ : ST_CMP;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // Entering with an empty table skips the compare and adds at once.
        if (free_r > {1'b0, scan_r} &&
            ram_rdata == {pend_r, sym_r}) begin
          pend_nxt  = scan_r;
          state_nxt = ST_IDLE;
        end else if (free_r > lzwc_pkg::FREE_BITS'(scan_inc)) begin
          scan_nxt  = scan_inc[lzwc_pkg::CODE_BITS-1:0];
          state_nxt = ST_READ;
        end else begin
          do_nm = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (two_r) begin
            res0_nxt = res1_r;
            two_nxt  = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_nm) begin
      res0_nxt  = '{code: pend_r, code_width: width_r, last: 1'b1};
      two_nxt   = 1'b0;
      pend_nxt  = lzwc_pkg::CODE_BITS'(sym_r);
      state_nxt = ST_EMIT;
      if (free_r != lzwc_pkg::TABLE_FULL) begin
        ram_we   = 1'b1;
        free_nxt = free_inc;
        if ((free_inc >> width_r) != '0 && width_r < lzwc_pkg::MAX_WIDTH) begin
          width_nxt = width_r + lzwc_pkg::WIDTH_BITS'(1);
        end
      end else begin
        metric_nxt = metric_new;
        if ($signed(metric_new) < $signed({{(lzwc_pkg::METRIC_BITS-lzwc_pkg::THR_BITS)
                                            {thr_r[lzwc_pkg::THR_BITS-1]}}, thr_r})) begin
          res0_nxt.last = 1'b0;
          res1_nxt   = '{code: lzwc_pkg::CLEAR_CODE, code_width: width_r, last: 1'b1};
          two_nxt    = 1'b1;
          free_nxt   = lzwc_pkg::FREE_BITS'(lzwc_pkg::FIRST_FREE);
          width_nxt  = lzwc_pkg::START_WIDTH;
          metric_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      free_r   <= lzwc_pkg::FREE_BITS'(lzwc_pkg::FIRST_FREE);
      pend_r   <= '0;
      pvalid_r <= 1'b0;
      width_r  <= lzwc_pkg::START_WIDTH;
      metric_r <= '0;
      thr_r    <= lzwc_pkg::THR_RESET;
      two_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      free_r   <= free_nxt;
      pend_r   <= pend_nxt;
      pvalid_r <= pvalid_nxt;
      width_r  <= width_nxt;
      metric_r <= metric_nxt;
      two_r    <= two_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
    sym_r  <= sym_nxt;
    scan_r <= scan_nxt;
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

endmodule
